[hdl/cpa_pkg.sv]
// Package for the color palette allocator: payload structs, op codes,
// sequencer states and constants. Depends on nothing.
`timescale 1ns / 1ps
package cpa_pkg;
  localparam int PaletteSizeDef  = 256;
  localparam int CoarseLevelsDef = 4;
  localparam logic [7:0] LockedCode = 8'd3;
  localparam logic [7:0] FirstFreeReset = 8'd16;

  typedef enum logic [1:0] {
    FUNC_GET     = 2'd0,
    FUNC_LOCK    = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_EXPIRE  = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [14:0] color;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  entry_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0] assigned_index;
    logic       load_palette;
    logic [7:0] load_red;
    logic [7:0] load_green;
    logic [7:0] load_blue;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_LOOK2, ST_CNT, ST_CNT2, ST_SCAN, ST_SCAN2,
    ST_REC, ST_COARSE, ST_COARSE2, ST_COARSE3, ST_EXP, ST_EXP2, ST_DONE
  } state_t;

  function automatic logic [14:0] coarse_mask(input logic [1:0] lvl);
    logic [14:0] m;
    case (lvl)
      2'd0:    m = 15'h7BDE;
      2'd1:    m = 15'h739C;
      2'd2:    m = 15'h6318;
      default: m = 15'h4210;
    endcase
    return m;
  endfunction

  // Saturating lock rule applied to one count.
  function automatic logic [7:0] lock_count(input logic [7:0] c);
    logic [7:0] r;
    if (c >= LockedCode) r = (c == 8'hFF) ? c : c + 8'd1;
    else r = LockedCode;
    return r;
  endfunction
endpackage

[hdl/color_palette_allocator_core.sv]
// Top level of the color palette allocator: APB register, sequencer and
// the palette stores. Depends on cpa_pkg and cpa_mem.
`timescale 1ns / 1ps
//  channel   direction  handshake              payload
//  command   in         start & !busy          cmd (cmd_t)
//  result    out        done strobe, 1 cycle   result (result_t)
//  config    in         APB write, pready=1    first_free_entry at 0x0
//
// Lock and release pass through ST_CNT, ST_CNT2 and ST_DONE before their
// result word shows; a get that hits a live entry first reads the color
// table in ST_LOOK and ST_LOOK2. A get may scan the whole palette and then
// walk all coarse levels, and expire visits every entry. The scan and
// expire loops each read one count per entry through the single port of
// the count memory, in ST_SCAN/ST_SCAN2 and ST_EXP/ST_EXP2.
// After reset the block sweeps all stores clear, one address a cycle over
// the coarse store's address range (the longest), and is busy meanwhile.
// The receiver cannot stall: the result word shows for one cycle with done.
module color_palette_allocator_core
  import cpa_pkg::*;
#(
  parameter int PALETTE_SIZE  = PaletteSizeDef,
  parameter int COARSE_LEVELS = CoarseLevelsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cpa_pkg::cmd_t        cmd,
  output logic                 busy,
  output logic                 done,
  output cpa_pkg::result_t     result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  // Configuration register.
  logic [7:0] first_free;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, first_free} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) first_free <= FirstFreeReset;
    else if (psel && penable && pwrite && paddr == 2'd0) first_free <= pwdata[7:0];
  end
  wire [7:0] ffe = (first_free == 8'd0) ? 8'd1 : first_free;

  // Stores.
  logic        c2e_we, ec_we, cnt_we, k2e_we, kc_we;
  logic [14:0] c2e_a;  logic [7:0] c2e_wd, c2e_rd;
  logic [7:0]  ec_a;   logic [14:0] ec_wd, ec_rd;
  logic [7:0]  cnt_a;  logic [7:0] cnt_wd, cnt_rd;
  logic [16:0] k2e_a;  logic [7:0] k2e_wd, k2e_rd;
  logic [9:0]  kc_a;   logic [14:0] kc_wd, kc_rd;

  cpa_mem #(.AW(15), .DW(8))  u_c2e (.clk, .we(c2e_we), .addr(c2e_a), .wdata(c2e_wd),
                                     .rdata(c2e_rd));
  cpa_mem #(.AW(8),  .DW(15)) u_ec  (.clk, .we(ec_we), .addr(ec_a), .wdata(ec_wd),
                                     .rdata(ec_rd));
  cpa_mem #(.AW(8),  .DW(8))  u_cnt (.clk, .we(cnt_we), .addr(cnt_a), .wdata(cnt_wd),
                                     .rdata(cnt_rd));
  cpa_mem #(.AW(17), .DW(8))  u_k2e (.clk, .we(k2e_we), .addr(k2e_a), .wdata(k2e_wd),
                                     .rdata(k2e_rd));
  cpa_mem #(.AW(10), .DW(15)) u_kc  (.clk, .we(kc_we), .addr(kc_a), .wdata(kc_wd),
                                     .rdata(kc_rd));

  state_t     state, state_next;
  cmd_t       cur, cur_next;
  logic [16:0] ptr, ptr_next;        // clear sweep address
  logic [7:0]  n, n_next;            // entry under work / scan pointer
  logic [7:0]  last, last_next;
  logic [1:0]  lvl, lvl_next;
  logic [14:0] mc, mc_next;          // masked color for coarse levels
  logic        claim, claim_next;    // get found a free entry
  result_t     res_next;

  // Entry pointers step modulo PALETTE_SIZE.
  wire [8:0]    n_plus    = {1'b0, n} + 9'd1;
  wire [8:0]    last_plus = {1'b0, last} + 9'd1;
  wire [7:0]    n_inc     = (n_plus == 9'(PALETTE_SIZE)) ? 8'd0 : n_plus[7:0];
  wire [7:0]    last_inc  = (last_plus == 9'(PALETTE_SIZE)) ? 8'd0 : last_plus[7:0];
  wire          idx_ok  = (cur.entry_index != 8'd0) &&
                          ({1'b0, cur.entry_index} < 9'(PALETTE_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ptr   <= '0;
      last  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      last  <= last_next;
      done  <= (state == ST_DONE);
    end
    cur <= cur_next;
    n   <= n_next;
    lvl <= lvl_next;
    mc  <= mc_next;
    claim <= claim_next;
    if (state != ST_DONE) result <= res_next;
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cur_next = cur; ptr_next = ptr; n_next = n; last_next = last;
    lvl_next = lvl; mc_next = mc; claim_next = claim; res_next = result;
    c2e_we = 1'b0; ec_we = 1'b0; cnt_we = 1'b0; k2e_we = 1'b0; kc_we = 1'b0;
    c2e_a = cur.color; c2e_wd = n;
    ec_a = n; ec_wd = cur.color;
    cnt_a = n; cnt_wd = lock_count(cnt_rd);
    k2e_a = {lvl, mc}; k2e_wd = n;
    kc_a = {lvl, n}; kc_wd = mc;
    case (state)
      ST_CLEAR: begin
        c2e_we = 1'b1; c2e_a = ptr[14:0]; c2e_wd = '0;
        ec_we = 1'b1; ec_a = ptr[7:0]; ec_wd = '0;
        cnt_we = 1'b1; cnt_a = ptr[7:0]; cnt_wd = '0;
        k2e_we = 1'b1; k2e_a = ptr; k2e_wd = '0;
        kc_we = 1'b1; kc_a = ptr[9:0]; kc_wd = '0;
        ptr_next = ptr + 17'd1;
        if (ptr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cur_next = cmd;
          res_next = '0;
          claim_next = 1'b0;
          // Clear the coarse-lock mark left by an earlier command.
          lvl_next = '0;
          mc_next = '0;
          case (func_t'(cmd.func))
            FUNC_GET: begin c2e_a = cmd.color; state_next = ST_LOOK; end
            FUNC_EXPIRE: begin n_next = '0; state_next = ST_EXP; end
            default: begin n_next = cmd.entry_index; state_next = ST_CNT; end
          endcase
        end
      end
      ST_LOOK: begin  // c2e read in flight
        state_next = ST_LOOK2;
      end
      ST_LOOK2: begin
        n_next = c2e_rd;
        state_next = ST_CNT;
      end
      ST_CNT: begin  // issue reads of count (and entry color) at n
        state_next = ST_CNT2;
      end
      ST_CNT2: begin
        state_next = ST_DONE;
        case (func_t'(cur.func))
          FUNC_LOCK: begin
            if (idx_ok) cnt_we = 1'b1;
          end
          FUNC_RELEASE: begin
            if (idx_ok && cnt_rd >= LockedCode) begin
              cnt_we = 1'b1; cnt_wd = cnt_rd - 8'd1;
            end
          end
          default: begin
            if (claim) begin
              // claimed entry: lock and record it
              cnt_we = 1'b1; c2e_we = 1'b1; ec_we = 1'b1;
              last_next = n;
              lvl_next = '0; mc_next = cur.color & coarse_mask(2'd0);
              res_next.assigned_index = n;
              res_next.load_palette = 1'b1;
              res_next.load_red = cur.red;
              res_next.load_green = cur.green;
              res_next.load_blue = cur.blue;
              state_next = ST_REC;
            end else if (lvl == 2'd3 && mc == 15'h7FFF) begin
              // coarse hit already in n: lock it (n nonzero here)
              cnt_we = 1'b1;
            end else if (n != 8'd0 && cnt_rd != 8'd0 && ec_rd == cur.color) begin
              cnt_we = 1'b1;
              res_next.assigned_index = n;
            end else begin
              n_next = last_inc;
              state_next = ST_SCAN;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (n == last) begin
          lvl_next = '0; mc_next = cur.color & coarse_mask(2'd0);
          state_next = ST_COARSE;
        end else begin
          state_next = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        if (n != 8'd0 && cnt_rd == 8'd0 && n >= ffe) begin
          claim_next = 1'b1;
          state_next = ST_CNT2;
        end else begin
          n_next = n_inc;
          state_next = ST_SCAN;
        end
      end
      ST_REC: begin
        k2e_we = 1'b1; kc_we = 1'b1;
        if (lvl == 2'(COARSE_LEVELS - 1)) state_next = ST_DONE;
        else begin
          lvl_next = lvl + 2'd1;
          mc_next = mc & coarse_mask(lvl + 2'd1);
        end
      end
      ST_COARSE: state_next = ST_COARSE2;  // k2e read in flight
      ST_COARSE2: begin
        n_next = k2e_rd;
        kc_a = {lvl, k2e_rd};
        state_next = ST_COARSE3;
      end
      ST_COARSE3: begin
        if (kc_rd == mc) begin
          res_next.assigned_index = n;
          if (n != 8'd0 && {1'b0, n} < 9'(PALETTE_SIZE)) begin
            lvl_next = 2'd3; mc_next = 15'h7FFF;  // marks coarse lock
            state_next = ST_CNT;
          end else state_next = ST_DONE;
        end else if (lvl == 2'(COARSE_LEVELS - 1)) begin
          state_next = ST_DONE;
        end else begin
          lvl_next = lvl + 2'd1;
          mc_next = mc & coarse_mask(lvl + 2'd1);
          state_next = ST_COARSE;
        end
      end
      ST_EXP: state_next = ST_EXP2;
      ST_EXP2: begin
        if (cnt_rd == 8'd1 || cnt_rd == 8'd2) begin
          cnt_we = 1'b1; cnt_wd = cnt_rd - 8'd1;
        end
        n_next = n_inc;
        state_next = (n_inc == 8'd0) ? ST_DONE : ST_EXP;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

[hdl/cpa_mem.sv]
// Generic single-port synchronous memory with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module cpa_mem #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[hdl/cpa_checker.sv]
// Port-level checker for the color palette allocator, bound to the top.
// Depends on cpa_pkg.
`timescale 1ns / 1ps
module cpa_checker
  import cpa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input cpa_pkg::result_t result
);
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("not busy after start");
  a_load_nz: assert property (@(posedge clk) disable iff (rst)
    (done && result.load_palette) |-> result.assigned_index != 8'd0)
    else $error("load of entry 0");
  a_nodata: assert property (@(posedge clk) disable iff (rst)
    (done && !result.load_palette) |-> result.load_red == 8'd0)
    else $error("load data without load");
endmodule

bind color_palette_allocator_core cpa_checker u_chk (
  .clk, .rst, .start, .busy, .done, .result
);
